/* src/lfpd_pkg.sv */
// Shared types and constants for the line-follower PD steering block.
`timescale 1ns / 1ps
`default_nettype none

package lfpd_pkg;

   localparam int SAMPLE_W   = 10;
   localparam int GAIN_W     = 10;
   localparam int SPEED_W    = 11;
   localparam int THRESH_W   = 10;
   localparam int DRIVE_W    = 12;
   localparam int POS_W      = 4;
   localparam int CORR_W     = 12;
   localparam int QUO_W      = 4;
   localparam int PID_W      = 16;
   localparam int IN_DATA_W  = 24;
   localparam int OUT_DATA_W = 40;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 11;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_KP         = 2'd0,
      CSR_KD         = 2'd1,
      CSR_BASE_SPEED = 2'd2,
      CSR_THRESHOLD  = 2'd3
   } csr_index_type;

   localparam logic [GAIN_W-1:0]   KP_RESET        = 10'd140;
   localparam logic [GAIN_W-1:0]   KD_RESET        = 10'd11;
   localparam logic [SPEED_W-1:0]  BASE_RESET      = 11'd568;
   localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 10'd200;

   localparam logic signed [POS_W-1:0] POS_CENTER     = 4'sd0;
   localparam logic signed [POS_W-1:0] POS_LEFT       = 4'sd1;
   localparam logic signed [POS_W-1:0] POS_RIGHT      = -4'sd1;
   localparam logic signed [POS_W-1:0] POS_LOST_LEFT  = 4'sd5;
   localparam logic signed [POS_W-1:0] POS_LOST_RIGHT = -4'sd5;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

/* src/lfpd_pos.sv */
// Line position encoder from the two thresholded sensor samples.
`timescale 1ns / 1ps
`default_nettype none

module lfpd_pos (
   input  wire logic [lfpd_pkg::SAMPLE_W-1:0]       left_sample,
   input  wire logic [lfpd_pkg::SAMPLE_W-1:0]       right_sample,
   input  wire logic [lfpd_pkg::THRESH_W-1:0]       threshold,
   input  wire logic                                prev_negative,
   output logic signed [lfpd_pkg::POS_W-1:0]        line_position
);

   logic left_on;
   logic right_on;

   assign left_on  = left_sample >= threshold;
   assign right_on = right_sample >= threshold;

   always_comb begin
      case ({left_on, right_on})
         2'b11:   line_position = lfpd_pkg::POS_CENTER;
         2'b10:   line_position = lfpd_pkg::POS_LEFT;
         2'b01:   line_position = lfpd_pkg::POS_RIGHT;
         default: line_position = prev_negative ? lfpd_pkg::POS_LOST_RIGHT
                                                : lfpd_pkg::POS_LOST_LEFT;
      endcase
   end

endmodule

`default_nettype wire

/* src/lfpd_div.sv */
// Restoring serial divider: one quotient bit per cycle of the small dividend.
`timescale 1ns / 1ps
`default_nettype none

module lfpd_div #(
   parameter int DIVISOR_W = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [lfpd_pkg::QUO_W-1:0]    dividend,
   input  wire logic [DIVISOR_W-1:0]          divisor,
   output logic      [lfpd_pkg::QUO_W-1:0]    quotient,
   output lfpd_pkg::div_status_type           status
);

   localparam int QW    = lfpd_pkg::QUO_W;
   localparam int CMP_W = (DIVISOR_W > QW + 1) ? DIVISOR_W : QW + 1;
   localparam int STEP_W = $clog2(QW);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [QW-1:0]     rem_ff, rem_in;
   logic [QW-1:0]     shr_ff, shr_in;

   logic [QW:0]       trial;
   logic [CMP_W-1:0]  trial_ext;
   logic [CMP_W-1:0]  divisor_ext;
   logic [CMP_W-1:0]  diff_ext;
   logic              fits;

   // partial remainder never exceeds a prefix of the 4-bit dividend
   assign trial       = {rem_ff, shr_ff[QW-1]};
   assign trial_ext   = CMP_W'(trial);
   assign divisor_ext = CMP_W'(divisor);
   assign fits        = trial_ext >= divisor_ext;
   assign diff_ext    = trial_ext - divisor_ext;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      shr_in  = shr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         shr_in  = dividend;
      end else if (busy_ff) begin
         rem_in  = fits ? diff_ext[QW-1:0] : trial[QW-1:0];
         shr_in  = {shr_ff[QW-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      shr_ff <= shr_in;
   end

   assign quotient    = shr_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

/* src/line_follow_pd_steering_top.sv */
// Sequence: an accepted req word passes S_START, the 4-step serial divider in S_DIV,
//   S_PTERM, S_DTERM and S_CLAMP, which loads the rsp register once it is free.
// The one-hot sequencer takes a new req only in S_IDLE, after the last word left S_CLAMP.
// A finished rsp word may wait in the output register while the next req is taken.
// Reset (synchronous, active high): gains, base speed and threshold to defaults, previous
//   position, step counter and change parity cleared, both channels idle.
`timescale 1ns / 1ps
`default_nettype none

module line_follow_pd_steering_top #(
   parameter int STEP_COUNT_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // req_tdata: left_sample[9:0], right_sample[19:10], zero pad
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [lfpd_pkg::IN_DATA_W-1:0]      req_tdata,
   // rsp_tdata: left_drive[11:0], right_drive[23:12], line_position[27:24],
   //            correction[39:28]
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [lfpd_pkg::OUT_DATA_W-1:0]          rsp_tdata,
   input  wire logic                                csr_we,
   input  wire logic [lfpd_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  wire logic [lfpd_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CW = STEP_COUNT_BITS;
   localparam int PW = lfpd_pkg::POS_W;
   localparam int QW = lfpd_pkg::QUO_W;
   localparam int XW = lfpd_pkg::PID_W;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_START = 6'b000010,
      S_DIV   = 6'b000100,
      S_PTERM = 6'b001000,
      S_DTERM = 6'b010000,
      S_CLAMP = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [lfpd_pkg::GAIN_W-1:0]   kp_ff;
   logic [lfpd_pkg::GAIN_W-1:0]   kd_ff;
   logic [lfpd_pkg::SPEED_W-1:0]  base_ff;
   logic [lfpd_pkg::THRESH_W-1:0] thresh_ff;

   logic signed [PW-1:0] prev_ff;
   logic signed [PW-1:0] pos_ff;
   logic [CW-1:0]        count_ff;
   logic                 parity_ff;
   logic signed [XW-1:0] term_ff, term_in;
   logic signed [XW-1:0] pid_ff, pid_in;

   logic                 rsp_valid_ff;
   logic [lfpd_pkg::OUT_DATA_W-1:0] rsp_data_ff;

   logic signed [PW-1:0] pos_new;
   logic                 accept;
   logic                 load_rsp;

   logic signed [PW:0]   diff;
   logic [PW:0]          diff_mag;
   logic [QW-1:0]        quotient;
   lfpd_pkg::div_status_type div_status;
   logic signed [PW:0]   deriv;

   logic [lfpd_pkg::GAIN_W+2:0] kp_x5;
   logic signed [XW-1:0] dprod;
   logic signed [XW-1:0] lim;
   logic signed [XW-1:0] clamped;
   logic [lfpd_pkg::CORR_W-1:0]  corr;
   logic [lfpd_pkg::DRIVE_W:0]   base_ext;
   logic [lfpd_pkg::DRIVE_W:0]   corr_ext;
   logic [lfpd_pkg::DRIVE_W:0]   left_full;
   logic [lfpd_pkg::DRIVE_W:0]   right_full;

   lfpd_pos u_pos (
      .left_sample   (req_tdata[9:0]),
      .right_sample  (req_tdata[19:10]),
      .threshold     (thresh_ff),
      .prev_negative (prev_ff[PW-1]),
      .line_position (pos_new)
   );

   assign diff     = {pos_ff[PW-1], pos_ff} - {prev_ff[PW-1], prev_ff};
   assign diff_mag = diff[PW] ? -diff : diff;

   lfpd_div #(
      .DIVISOR_W (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_START),
      .dividend (diff_mag[QW-1:0]),
      .divisor  (count_ff),
      .quotient (quotient),
      .status   (div_status)
   );

   assign deriv = diff[PW] ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});

   assign accept     = req_tvalid && req_tready;
   assign req_tready = state_ff == S_IDLE;
   assign load_rsp   = (state_ff == S_CLAMP) && (!rsp_valid_ff || rsp_tready);

   // proportional term: |pos| is 0, 1 or 5, so kp*5 is a shift and add
   assign kp_x5 = {1'b0, kp_ff, 2'b00} + (lfpd_pkg::GAIN_W + 3)'(kp_ff);

   always_comb begin
      case (pos_ff)
         lfpd_pkg::POS_LEFT:       term_in = $signed(XW'(kp_ff));
         lfpd_pkg::POS_RIGHT:      term_in = -$signed(XW'(kp_ff));
         lfpd_pkg::POS_LOST_LEFT:  term_in = $signed(XW'(kp_x5));
         lfpd_pkg::POS_LOST_RIGHT: term_in = -$signed(XW'(kp_x5));
         default:                  term_in = '0;
      endcase
   end

   assign dprod  = $signed(XW'(kd_ff)) * $signed({{(XW-PW-1){deriv[PW]}}, deriv});
   assign pid_in = term_ff + dprod;

   assign lim = $signed(XW'(base_ff));

   always_comb begin
      if (pid_ff > lim) begin
         clamped = lim;
      end else if (pid_ff < -lim) begin
         clamped = -lim;
      end else begin
         clamped = pid_ff;
      end
   end

   assign corr       = clamped[lfpd_pkg::CORR_W-1:0];
   assign base_ext   = (lfpd_pkg::DRIVE_W + 1)'(base_ff);
   assign corr_ext   = {corr[lfpd_pkg::CORR_W-1], corr};
   assign left_full  = base_ext - corr_ext;
   assign right_full = base_ext + corr_ext;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (accept) state_in = S_START;
         S_START: state_in = S_DIV;
         S_DIV:   if (div_status.done) state_in = S_PTERM;
         S_PTERM: state_in = S_DTERM;
         S_DTERM: state_in = S_CLAMP;
         S_CLAMP: if (load_rsp) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         kp_ff        <= lfpd_pkg::KP_RESET;
         kd_ff        <= lfpd_pkg::KD_RESET;
         base_ff      <= lfpd_pkg::BASE_RESET;
         thresh_ff    <= lfpd_pkg::THRESHOLD_RESET;
         prev_ff      <= lfpd_pkg::POS_CENTER;
         count_ff     <= '0;
         parity_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (lfpd_pkg::csr_index_type'(csr_addr))
               lfpd_pkg::CSR_KP:         kp_ff     <= csr_wdata[lfpd_pkg::GAIN_W-1:0];
               lfpd_pkg::CSR_KD:         kd_ff     <= csr_wdata[lfpd_pkg::GAIN_W-1:0];
               lfpd_pkg::CSR_BASE_SPEED: base_ff   <= csr_wdata;
               lfpd_pkg::CSR_THRESHOLD:  thresh_ff <= csr_wdata[lfpd_pkg::THRESH_W-1:0];
               default: ;
            endcase
         end
         // saturating step count, bumped before the divide uses it
         if (accept && (count_ff != '1)) begin
            count_ff <= count_ff + CW'(1);
         end
         if (load_rsp) begin
            prev_ff <= pos_ff;
            if (pos_ff != prev_ff) begin
               if (parity_ff) begin
                  count_ff  <= '0;
                  parity_ff <= 1'b0;
               end else begin
                  parity_ff <= 1'b1;
               end
            end
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pos_ff <= pos_new;
      end
      if (state_ff == S_PTERM) begin
         term_ff <= term_in;
      end
      if (state_ff == S_DTERM) begin
         pid_ff <= pid_in;
      end
      if (load_rsp) begin
         rsp_data_ff <= {corr, pos_ff, right_full[lfpd_pkg::DRIVE_W-1:0],
                         left_full[lfpd_pkg::DRIVE_W-1:0]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !div_status.busy)
      else $error("divider busy while sequencer idle");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_START) |-> (count_ff != '0))
      else $error("zero divisor at divide start");

   a_quo_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PTERM) |-> (quotient <= QW'(10)))
      else $error("derivative magnitude out of range");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == S_CLAMP))
      else $error("rsp word raised outside clamp step");

endmodule

`default_nettype wire
